>>> src/svgpc_pkg.sv
`timescale 1ns / 1ps

package svgpc_pkg;

   // Longest path string accepted; the byte past it is reported as too long
   localparam int MAX_LENGTH = 1023;
   localparam int CHAR_COUNT_WIDTH = $clog2(MAX_LENGTH + 2);

   typedef logic [CHAR_COUNT_WIDTH-1:0] char_count_type;

   localparam char_count_type MAX_COUNT = CHAR_COUNT_WIDTH'(MAX_LENGTH);

   // Version register
   typedef logic [1:0] svg_version_type;

   localparam svg_version_type VER_1_0   = 2'd0;
   localparam svg_version_type VER_1_1   = 2'd1;
   localparam svg_version_type VER_1_2   = 2'd2;
   localparam svg_version_type VER_RESET = VER_1_1;

   typedef enum logic [3:0] {
      ERR_NONE         = 4'd0,
      ERR_LEADING_DOT  = 4'd1,
      ERR_LEADING_EXP  = 4'd2,
      ERR_ARC_EXCLUDED = 4'd3,
      ERR_Z_NEEDS_1_1  = 4'd4,
      ERR_BAD_BYTE     = 4'd5,
      ERR_ARG_COUNT    = 4'd6,
      ERR_ARC_FLAG     = 4'd7,
      ERR_TOO_LONG     = 4'd8,
      ERR_EMPTY        = 4'd9
   } err_code_type;

   // Number scanner phase
   typedef enum logic [1:0] {
      NUM_OUTSIDE  = 2'd0,
      NUM_MANTISSA = 2'd1,
      NUM_EXP_MARK = 2'd2,
      NUM_EXPONENT = 2'd3
   } num_phase_type;

   // Shape of the current token, for arc flag checks
   typedef enum logic [1:0] {
      SHAPE_EMPTY = 2'd0,
      SHAPE_FLAG  = 2'd1,
      SHAPE_OTHER = 2'd2
   } token_shape_type;

   // Arguments per group of each command
   localparam logic [2:0] GROUP_NONE = 3'd0;
   localparam logic [2:0] GROUP_HV   = 3'd1;
   localparam logic [2:0] GROUP_LMT  = 3'd2;
   localparam logic [2:0] GROUP_QS   = 3'd4;
   localparam logic [2:0] GROUP_C    = 3'd6;
   localparam logic [2:0] GROUP_A    = 3'd7;

   // Arc arguments that must be flags (zero-based)
   localparam logic [2:0] ARC_FLAG_FIRST  = 3'd3;
   localparam logic [2:0] ARC_FLAG_SECOND = 3'd4;

   typedef struct packed {
      logic [2:0]      group_size;
      logic [2:0]      args_seen;
      logic            group_count_nonzero;
      logic            is_arc_command;
      num_phase_type   number_phase;
      token_shape_type flag_token_shape;
      char_count_type  char_count;
      err_code_type    first_error_code;
   } parse_state_type;

   typedef struct packed {
      err_code_type error_now;
      logic         string_done;
      logic         string_valid;
      err_code_type first_error;
   } rsp_data_type;

endpackage

>>> src/svgpc_ifs.sv
`timescale 1ns / 1ps

interface svgpc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       char_present;
   logic       end_of_string;

   modport source (output valid, output char_byte, output char_present,
                   output end_of_string, input ready);
   modport sink (input valid, input char_byte, input char_present,
                 input end_of_string, output ready);
endinterface

interface svgpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] error_now;
   logic       string_done;
   logic       string_valid;
   logic [3:0] first_error;

   modport source (output valid, output error_now, output string_done,
                   output string_valid, output first_error, input ready);
   modport sink (input valid, input error_now, input string_done,
                 input string_valid, input first_error, output ready);
endinterface

>>> src/svgpc_core.sv
`timescale 1ns / 1ps

module svgpc_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [7:0]                 char_byte,
   input  logic                       char_present,
   input  logic                       end_of_string,
   input  svgpc_pkg::svg_version_type svg_version,
   output svgpc_pkg::rsp_data_type    result
);
   import svgpc_pkg::*;

   parse_state_type state_ff;
   parse_state_type state_in;

   function automatic err_code_type keep_first(err_code_type cur, err_code_type e);
      return (cur != ERR_NONE) ? cur : e;
   endfunction

   function automatic token_shape_type shape_add(token_shape_type sh, logic [7:0] b);
      return (sh == SHAPE_EMPTY && (b == "0" || b == "1")) ? SHAPE_FLAG : SHAPE_OTHER;
   endfunction

   // Error raised when the current number closes
   function automatic err_code_type finish_err(parse_state_type s);
      err_code_type e;
      e = ERR_NONE;
      if (s.number_phase != NUM_OUTSIDE && s.group_size != GROUP_NONE &&
          s.is_arc_command &&
          (s.args_seen == ARC_FLAG_FIRST || s.args_seen == ARC_FLAG_SECOND) &&
          s.flag_token_shape != SHAPE_FLAG) begin
         e = ERR_ARC_FLAG;
      end
      return e;
   endfunction

   // Close the current number and count it as an argument
   function automatic parse_state_type finish_state(parse_state_type s);
      parse_state_type r;
      logic [2:0]      nargs;
      r = s;
      nargs = s.args_seen + 3'd1;
      if (s.number_phase != NUM_OUTSIDE) begin
         r.number_phase = NUM_OUTSIDE;
         if (s.group_size != GROUP_NONE) begin
            if (nargs >= s.group_size) begin
               r.args_seen = 3'd0;
               r.group_count_nonzero = 1'b1;
            end else begin
               r.args_seen = nargs;
            end
         end
         r.flag_token_shape = SHAPE_EMPTY;
      end
      return r;
   endfunction

   function automatic err_code_type group_check(parse_state_type s);
      return (s.group_size != GROUP_NONE &&
              (s.args_seen != 3'd0 || !s.group_count_nonzero)) ? ERR_ARG_COUNT : ERR_NONE;
   endfunction

   function automatic parse_state_type set_command(parse_state_type s, logic [2:0] size,
                                                   logic arc);
      parse_state_type r;
      r = s;
      r.group_size = size;
      r.args_seen = 3'd0;
      r.group_count_nonzero = 1'b0;
      r.is_arc_command = arc;
      return r;
   endfunction

   // Work out one request against the current string state
   always_comb begin
      parse_state_type s;
      err_code_type    err;
      err_code_type    fe;
      char_count_type  cnt;
      logic            cmd_hit;
      logic [2:0]      cmd_size;
      logic            cmd_arc;

      s = state_ff;
      err = ERR_NONE;
      cnt = state_ff.char_count;
      cmd_hit = 1'b0;
      cmd_size = GROUP_NONE;
      cmd_arc = 1'b0;

      if (char_present && state_ff.char_count <= MAX_COUNT) begin
         cnt = state_ff.char_count + CHAR_COUNT_WIDTH'(1);
         s.char_count = cnt;
         if (cnt > MAX_COUNT) begin
            err = ERR_TOO_LONG;
         end else if (char_byte < 8'd32 || char_byte == 8'd127) begin
            // skip control bytes
         end else if (char_byte >= "0" && char_byte <= "9") begin
            if (s.number_phase == NUM_EXP_MARK) s.number_phase = NUM_EXPONENT;
            else if (s.number_phase == NUM_OUTSIDE) s.number_phase = NUM_MANTISSA;
            s.flag_token_shape = shape_add(s.flag_token_shape, char_byte);
         end else if (char_byte == ".") begin
            if (s.number_phase == NUM_OUTSIDE) begin
               err = ERR_LEADING_DOT;
               s.number_phase = NUM_MANTISSA;
            end
            s.flag_token_shape = shape_add(s.flag_token_shape, char_byte);
         end else if (char_byte == "e" || char_byte == "E") begin
            if (s.number_phase == NUM_OUTSIDE) err = ERR_LEADING_EXP;
            s.number_phase = NUM_EXP_MARK;
            s.flag_token_shape = shape_add(s.flag_token_shape, char_byte);
         end else if (char_byte == "-" || char_byte == "+") begin
            if (s.number_phase == NUM_EXP_MARK) begin
               s.number_phase = NUM_EXPONENT;
            end else begin
               err = finish_err(s);
               s = finish_state(s);
               s.number_phase = NUM_MANTISSA;
            end
            s.flag_token_shape = shape_add(s.flag_token_shape, char_byte);
         end else begin
            err = finish_err(s);
            s = finish_state(s);
            unique case (char_byte)
               " ", ",": ;
               "A", "a": begin
                  if (svg_version >= VER_1_2) err = keep_first(err, ERR_ARC_EXCLUDED);
                  else begin
                     cmd_hit = 1'b1;
                     cmd_size = GROUP_A;
                     cmd_arc = 1'b1;
                  end
               end
               "C", "c": begin
                  cmd_hit = 1'b1;
                  cmd_size = GROUP_C;
               end
               "H", "h", "V", "v": begin
                  cmd_hit = 1'b1;
                  cmd_size = GROUP_HV;
               end
               "L", "l", "M", "m", "T", "t": begin
                  cmd_hit = 1'b1;
                  cmd_size = GROUP_LMT;
               end
               "Q", "q", "S", "s": begin
                  cmd_hit = 1'b1;
                  cmd_size = GROUP_QS;
               end
               "Z": begin
                  if (svg_version == VER_1_0) err = keep_first(err, ERR_Z_NEEDS_1_1);
                  else cmd_hit = 1'b1;
               end
               "z": cmd_hit = 1'b1;
               default: err = keep_first(err, ERR_BAD_BYTE);
            endcase
            if (cmd_hit) begin
               err = keep_first(err, group_check(s));
               s = set_command(s, cmd_size, cmd_arc);
            end
         end
      end

      // End checks: close the last number and group
      if (end_of_string) begin
         if (cnt <= MAX_COUNT) begin
            err = keep_first(err, finish_err(s));
            s = finish_state(s);
            err = keep_first(err, group_check(s));
         end
         if (cnt == '0) err = ERR_EMPTY;
         else if (cnt > MAX_COUNT) err = ERR_TOO_LONG;
      end

      s.first_error_code = keep_first(state_ff.first_error_code, err);

      if (end_of_string) begin
         if (cnt == '0) fe = ERR_EMPTY;
         else if (cnt > MAX_COUNT) fe = ERR_TOO_LONG;
         else fe = s.first_error_code;
      end else begin
         fe = s.first_error_code;
      end

      result.error_now = err;
      result.string_done = end_of_string;
      result.string_valid = end_of_string && (fe == ERR_NONE);
      result.first_error = fe;

      // Drop all per-string state once the verdict is out
      state_in = s;
      if (end_of_string) state_in = '0;
   end

   // Hold the string state, advance on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/svg_path_data_checker.sv
`timescale 1ns / 1ps

// SVG path data syntax checker.
// Requests arrive on req_ch, one byte of path data each, with char_present
// (0 for a bare end marker) and end_of_string marking the last request of a
// string. Every request yields exactly one result on rsp_ch: the error found
// on that byte, the running first error and, on the end request, the verdict
// for the whole string.
// The SVG version register is written through csr_write_enable and
// csr_write_data; the user is to write it only while the block is idle; the
// block does not enforce this. 0 rejects 'Z', 2 or 3 rejects arcs. Each
// result is registered into the result register, or into the one-entry skid
// register while the result register is full and not being emptied.
// Throughput is one request per cycle while the skid register is empty, set
// by the single parse stage between request port and result register.
// A request is still taken while one result waits; with both full,
// req_ch.ready drops until the receiver takes a result. Reset clears the
// string state, empties both result registers and sets the version to 1.1.
module svg_path_data_checker (
   input  logic                       clock,
   input  logic                       reset,
   svgpc_req_if.sink                  req_ch,
   svgpc_rsp_if.source                rsp_ch,
   input  logic                       csr_write_enable,
   input  svgpc_pkg::svg_version_type csr_write_data
);
   import svgpc_pkg::*;

   svg_version_type svg_version_ff;
   rsp_data_type    result;
   rsp_data_type    out_data_ff;
   rsp_data_type    skid_data_ff;
   logic            out_valid_ff;
   logic            skid_valid_ff;
   logic            push;
   logic            pop;

   assign req_ch.ready = !skid_valid_ff;
   assign push = req_ch.valid && req_ch.ready;
   assign pop = out_valid_ff && rsp_ch.ready;

   // Version register
   always_ff @(posedge clock) begin
      if (reset) begin
         svg_version_ff <= VER_RESET;
      end else if (csr_write_enable) begin
         svg_version_ff <= csr_write_data;
      end
   end

   svgpc_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (push),
      .char_byte     (req_ch.char_byte),
      .char_present  (req_ch.char_present),
      .end_of_string (req_ch.end_of_string),
      .svg_version   (svg_version_ff),
      .result        (result)
   );

   // Result register and skid valids
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         out_valid_ff <= skid_valid_ff || push;
         skid_valid_ff <= skid_valid_ff && push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Result register and skid payloads
   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
            skid_data_ff <= result;
         end else begin
            out_data_ff <= result;
         end
      end else if (push) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.error_now = out_data_ff.error_now;
   assign rsp_ch.string_done = out_data_ff.string_done;
   assign rsp_ch.string_valid = out_data_ff.string_valid;
   assign rsp_ch.first_error = out_data_ff.first_error;

endmodule

>>> src/svgpc_checker.sv
`timescale 1ns / 1ps

module svgpc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] error_now,
   input logic       string_done,
   input logic       string_valid,
   input logic [3:0] first_error
);
   import svgpc_pkg::*;

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(error_now) && $stable(string_done) &&
         $stable(string_valid) && $stable(first_error))
      else $error("stalled result changed");

   // Reset empties the result side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A clean verdict carries no error at all
   a_valid_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && string_valid |->
         string_done && first_error == ERR_NONE && error_now == ERR_NONE)
      else $error("valid string reported with an error");

   // Mid-string results never carry a verdict
   a_no_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !string_done |-> !string_valid)
      else $error("verdict outside end of string");

   // Any error raises the running first error
   a_first_tracks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && error_now != ERR_NONE |-> first_error != ERR_NONE)
      else $error("error not recorded as first error");

endmodule

bind svg_path_data_checker svgpc_checker u_svgpc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .error_now    (rsp_ch.error_now),
   .string_done  (rsp_ch.string_done),
   .string_valid (rsp_ch.string_valid),
   .first_error  (rsp_ch.first_error)
);

>>> dv/svgpc_tb_pkg.sv
`timescale 1ns / 1ps

package svgpc_tb_pkg;
   import svgpc_pkg::*;

   // Version code above 1.2; the block treats it as 1.2
   localparam svg_version_type VER_ABOVE_1_2 = 2'd3;

   class path_syntax_scoreboard;
      svg_version_type version;
      logic [2:0]      grp_size;
      logic [2:0]      grp_args;
      logic            grp_complete;
      logic            in_arc;
      num_phase_type   phase;
      token_shape_type shape;
      int unsigned     char_total;
      err_code_type    first_err;
      rsp_data_type    results_due[$];
      int unsigned     mismatches;
      int unsigned     strings_seen;
      int unsigned     clean_strings;
      logic [9:0]      codes_seen;

      function new();
         version = VER_RESET;
         mismatches = 0;
         strings_seen = 0;
         clean_strings = 0;
         codes_seen = '0;
         clear_string();
      endfunction

      function int unsigned pending_count();
         return results_due.size();
      endfunction

      function err_code_type first_of(err_code_type cur, err_code_type e);
         return (cur != ERR_NONE) ? cur : e;
      endfunction

      function void clear_string();
         grp_size = GROUP_NONE;
         grp_args = '0;
         grp_complete = 1'b0;
         in_arc = 1'b0;
         phase = NUM_OUTSIDE;
         shape = SHAPE_EMPTY;
         char_total = 0;
         first_err = ERR_NONE;
      endfunction

      // Track whether the token so far is a lone '0' or '1'
      function void grow_token(logic [7:0] b);
         shape = (shape == SHAPE_EMPTY && (b == "0" || b == "1")) ? SHAPE_FLAG : SHAPE_OTHER;
      endfunction

      // Close the open number and count it as an argument
      function err_code_type close_number();
         err_code_type err;
         err = ERR_NONE;
         if (phase == NUM_OUTSIDE)
            return ERR_NONE;
         phase = NUM_OUTSIDE;
         if (grp_size != GROUP_NONE) begin
            if (in_arc && (grp_args == ARC_FLAG_FIRST || grp_args == ARC_FLAG_SECOND) &&
                shape != SHAPE_FLAG)
               err = ERR_ARC_FLAG;
            grp_args++;
            if (grp_args >= grp_size) begin
               grp_args = '0;
               grp_complete = 1'b1;
            end
         end
         shape = SHAPE_EMPTY;
         return err;
      endfunction

      function err_code_type group_short();
         if (grp_size != GROUP_NONE && (grp_args != 0 || !grp_complete))
            return ERR_ARG_COUNT;
         return ERR_NONE;
      endfunction

      function err_code_type start_command(logic [2:0] size, logic arc);
         err_code_type err;
         err = group_short();
         grp_size = size;
         grp_args = '0;
         grp_complete = 1'b0;
         in_arc = arc;
         return err;
      endfunction

      // Classify one present byte and advance the number and group state
      function err_code_type parse_char(logic [7:0] b);
         svg_version_type v;
         err_code_type    err;
         v = (version > VER_1_2) ? VER_1_2 : version;
         err = ERR_NONE;
         if (b < 8'd32 || b == 8'd127)
            return ERR_NONE;
         if (b >= "0" && b <= "9") begin
            if (phase == NUM_EXP_MARK)
               phase = NUM_EXPONENT;
            else if (phase == NUM_OUTSIDE)
               phase = NUM_MANTISSA;
            grow_token(b);
            return ERR_NONE;
         end
         if (b == ".") begin
            if (phase == NUM_OUTSIDE) begin
               err = ERR_LEADING_DOT;
               phase = NUM_MANTISSA;
            end
            grow_token(b);
            return err;
         end
         if (b == "e" || b == "E") begin
            if (phase == NUM_OUTSIDE)
               err = ERR_LEADING_EXP;
            phase = NUM_EXP_MARK;
            grow_token(b);
            return err;
         end
         if (b == "-" || b == "+") begin
            if (phase == NUM_EXP_MARK) begin
               phase = NUM_EXPONENT;
            end else begin
               err = close_number();
               phase = NUM_MANTISSA;
            end
            grow_token(b);
            return err;
         end
         err = close_number();
         case (b)
            " ", ",": ;
            "A", "a": begin
               if (v == VER_1_2)
                  err = first_of(err, ERR_ARC_EXCLUDED);
               else
                  err = first_of(err, start_command(GROUP_A, 1'b1));
            end
            "C", "c": err = first_of(err, start_command(GROUP_C, 1'b0));
            "H", "h", "V", "v": err = first_of(err, start_command(GROUP_HV, 1'b0));
            "L", "l", "M", "m", "T", "t": err = first_of(err, start_command(GROUP_LMT, 1'b0));
            "Q", "q", "S", "s": err = first_of(err, start_command(GROUP_QS, 1'b0));
            "Z": begin
               if (v == VER_1_0)
                  err = first_of(err, ERR_Z_NEEDS_1_1);
               else
                  err = first_of(err, start_command(GROUP_NONE, 1'b0));
            end
            "z": err = first_of(err, start_command(GROUP_NONE, 1'b0));
            default: err = first_of(err, ERR_BAD_BYTE);
         endcase
         return err;
      endfunction

      // Work out the result of one accepted request and queue it
      function void note_request(logic [7:0] b, logic present, logic eos);
         err_code_type err;
         err_code_type verdict;
         rsp_data_type want;
         err = ERR_NONE;
         if (present && char_total <= MAX_LENGTH) begin
            char_total++;
            if (char_total > MAX_LENGTH)
               err = ERR_TOO_LONG;
            else
               err = parse_char(b);
         end
         if (eos) begin
            if (char_total <= MAX_LENGTH) begin
               err = first_of(err, close_number());
               err = first_of(err, group_short());
            end
            if (char_total == 0)
               err = ERR_EMPTY;
            else if (char_total > MAX_LENGTH)
               err = ERR_TOO_LONG;
         end
         first_err = first_of(first_err, err);
         want.error_now = err;
         want.string_done = eos;
         if (eos) begin
            if (char_total == 0)
               verdict = ERR_EMPTY;
            else if (char_total > MAX_LENGTH)
               verdict = ERR_TOO_LONG;
            else
               verdict = first_err;
            want.string_valid = (verdict == ERR_NONE);
            want.first_error = verdict;
            strings_seen++;
            if (verdict == ERR_NONE)
               clean_strings++;
            codes_seen[int'(verdict)] = 1'b1;
            clear_string();
         end else begin
            want.string_valid = 1'b0;
            want.first_error = first_err;
         end
         results_due = {results_due, want};
      endfunction

      function void compare_field(string field, logic [3:0] want, logic [3:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      // Match one accepted result against the oldest queued one
      function void check_result(logic [3:0] err_now, logic done, logic ok, logic [3:0] first);
         rsp_data_type want;
         if (results_due.size() == 0) begin
            $display("%0t: result with none expected (error_now %0d, done %0b)",
                     $time, err_now, done);
            mismatches++;
            return;
         end
         want = results_due.pop_front();
         compare_field("error_now", want.error_now, err_now);
         compare_field("string_done", 4'(want.string_done), 4'(done));
         compare_field("string_valid", 4'(want.string_valid), 4'(ok));
         compare_field("first_error", want.first_error, first);
      endfunction
   endclass

endpackage

>>> dv/tb_svg_path_data_checker.sv
`timescale 1ns / 1ps

module tb_svg_path_data_checker;
   import svgpc_pkg::*;
   import svgpc_tb_pkg::*;

   localparam int          PHASE_ITEMS  = 115;
   localparam int          QUIET_LIMIT  = 4000;
   localparam int          DRAIN_CYCLES = 8;
   localparam logic [7:0]  DEL_BYTE     = 8'h7f;

   logic            clock;
   logic            reset;
   logic            csr_write_enable;
   svg_version_type csr_write_data;

   svgpc_req_if req_ch ();
   svgpc_rsp_if rsp_ch ();

   svg_path_data_checker u_top (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   path_syntax_scoreboard sb = new();
   logic [7:0]  path_text[$];
   string       cmd_letters = "MmLlHhVvCcSsQqTtAaZz";
   bit          idling_enabled = 1'b1;
   int unsigned requests_sent = 0;
   int unsigned quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Stall the result side at random
   always @(negedge clock) begin
      rsp_ch.ready = !(idling_enabled && $urandom_range(0, 99) < 23);
   end

   // Check results and watch for a stalled run
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.error_now, rsp_ch.string_done, rsp_ch.string_valid,
                            rsp_ch.first_error);
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
            $display("svg_path_data_checker: mismatch");
            $finish;
         end
      end
   end

   // Append one byte to the path text under construction
   function automatic void append_byte(logic [7:0] b);
      path_text = {path_text, b};
   endfunction

   // Offer one request, with random idle cycles first; hold until taken
   task automatic push_char(input logic [7:0] b, input logic present, input logic eos);
      while (idling_enabled && $urandom_range(0, 99) < 23) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.char_byte = b;
      req_ch.char_present = present;
      req_ch.end_of_string = eos;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(b, present, eos);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_ch.valid = 1'b0;
      while (sb.pending_count() != 0) @(negedge clock);
   endtask

   task automatic write_version(input svg_version_type v);
      drain_results();
      csr_write_enable = 1'b1;
      csr_write_data = v;
      @(negedge clock);
      csr_write_enable = 1'b0;
      sb.version = v;
   endtask

   // Send the built text as one string, with stray bare requests inside
   task automatic send_path(input bit bare_end);
      int n;
      n = path_text.size();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 39) == 0)
            push_char(8'($urandom), 1'b0, 1'b0);
         push_char(path_text[i], 1'b1, (i == n - 1) && !bare_end);
      end
      if (bare_end || n == 0)
         push_char(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic send_text(input string s, input bit bare_end);
      path_text.delete();
      for (int i = 0; i < s.len(); i++)
         append_byte(s[i]);
      send_path(bare_end);
   endtask

   function automatic void add_digits(int unsigned lo, int unsigned hi);
      repeat ($urandom_range(lo, hi)) append_byte("0" + 8'($urandom_range(0, 9)));
   endfunction

   function automatic void add_sign();
      if ($urandom_range(0, 1) != 0)
         append_byte("-");
      else
         append_byte("+");
   endfunction

   // Mostly well-formed numbers; flag slots get a lone 0 or 1 most of the time
   function automatic void add_number(bit flag_slot);
      if (flag_slot && $urandom_range(0, 9) != 0) begin
         append_byte("0" + 8'($urandom_range(0, 1)));
         return;
      end
      case ($urandom_range(0, 19))
         0: append_byte(".");
         1: append_byte("e");
         2, 3, 4: add_sign();
         default: ;
      endcase
      add_digits(1, 3);
      if ($urandom_range(0, 2) == 0) begin
         append_byte(".");
         add_digits(1, 2);
      end
      if ($urandom_range(0, 5) == 0) begin
         if ($urandom_range(0, 1) != 0)
            append_byte("e");
         else
            append_byte("E");
         if ($urandom_range(0, 1) != 0)
            add_sign();
         add_digits(1, 2);
      end
   endfunction

   function automatic void add_gap();
      case ($urandom_range(0, 29))
         0: ;  // no gap: neighbors may merge into one number
         1: append_byte(8'($urandom_range(0, 31)));
         2: append_byte(DEL_BYTE);
         3, 4, 5: append_byte(",");
         6: begin
            append_byte(",");
            append_byte(" ");
         end
         default: append_byte(" ");
      endcase
   endfunction

   function automatic int unsigned args_for(logic [7:0] c);
      case (c)
         "A", "a": return 32'(GROUP_A);
         "C", "c": return 32'(GROUP_C);
         "Q", "q", "S", "s": return 32'(GROUP_QS);
         "L", "l", "M", "m", "T", "t": return 32'(GROUP_LMT);
         "H", "h", "V", "v": return 32'(GROUP_HV);
         default: return 32'(GROUP_NONE);
      endcase
   endfunction

   // Build a path of a few commands with full groups, plus some breakage
   function automatic void build_path();
      logic [7:0]  cmd;
      int unsigned nargs;
      int unsigned ngroups;
      path_text.delete();
      if ($urandom_range(0, 11) == 0)
         add_number(1'b0);
      repeat ($urandom_range(1, 4)) begin
         cmd = cmd_letters[$urandom_range(0, cmd_letters.len() - 1)];
         if ($urandom_range(0, 19) == 0)
            append_byte(8'($urandom));
         if (path_text.size() != 0 && $urandom_range(0, 1) != 0)
            add_gap();
         append_byte(cmd);
         nargs = args_for(cmd);
         if (nargs == 0 || $urandom_range(0, 14) == 0)
            ngroups = 0;
         else
            ngroups = $urandom_range(1, 2);
         for (int g = 0; g < ngroups; g++) begin
            for (int k = 0; k < nargs; k++) begin
               // drop the last argument now and then
               if (!(k == nargs - 1 && $urandom_range(0, 24) == 0)) begin
                  add_gap();
                  add_number(nargs == GROUP_A && (k == ARC_FLAG_FIRST || k == ARC_FLAG_SECOND));
               end
            end
         end
      end
      if ($urandom_range(0, 3) == 0)
         add_gap();
   endfunction

   function automatic svg_version_type phase_version(int p);
      case (p)
         0: return VER_1_0;
         1: return VER_1_2;
         2: return VER_ABOVE_1_2;
         3: return VER_1_1;
         default: return VER_1_0;
      endcase
   endfunction

   initial begin
      int unsigned phase_goal;
      int unsigned long_len;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = VER_RESET;
      req_ch.valid = 1'b0;
      req_ch.char_byte = '0;
      req_ch.char_present = 1'b0;
      req_ch.end_of_string = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed strings at the reset version
      send_text("", 1'b1);
      send_text(".5", 1'b0);
      send_text("E1z", 1'b0);
      send_text("v1e-2", 1'b1);
      push_char(8'h00, 1'b1, 1'b0);
      push_char(8'hff, 1'b1, 1'b0);
      push_char("Q", 1'b1, 1'b1);
      send_text("a0,0,0,2,1,0,0", 1'b0);
      write_version(VER_1_0);
      send_text("Z", 1'b0);
      write_version(VER_1_2);
      send_text("M1 A", 1'b0);

      // Random paths, one version per phase; phase 3 runs without idling
      for (int p = 0; p < 5; p++) begin
         write_version(phase_version(p));
         idling_enabled = (p != 3);
         phase_goal = requests_sent + PHASE_ITEMS;
         while (requests_sent < phase_goal) begin
            if ($urandom_range(0, 19) == 0)
               drain_results();
            build_path();
            send_path($urandom_range(0, 4) == 0);
         end
      end

      // One string around the length limit, then a few short ones
      write_version(VER_1_1);
      idling_enabled = 1'b1;
      long_len = MAX_LENGTH - 1 + $urandom_range(0, 4);
      send_text("M0 0", 1'b0);
      path_text.delete();
      while (path_text.size() < long_len) begin
         append_byte(" ");
         append_byte("L");
         add_number(1'b0);
         append_byte(",");
         add_number(1'b0);
      end
      while (path_text.size() > long_len)
         void'(path_text.pop_back());
      send_path($urandom_range(0, 1) != 0);
      repeat (3) begin
         build_path();
         send_path(1'b0);
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d requests in %0d strings (%0d clean) over SVG versions 1.0, 1.1, 1.2 and 3",
               requests_sent, sb.strings_seen, sb.clean_strings);
      $display("String verdict codes reached (bit per code): %b", sb.codes_seen);
      if (sb.mismatches == 0)
         $display("svg_path_data_checker: match");
      else
         $display("svg_path_data_checker: mismatch");
      $finish;
   end

endmodule
